// ===== rtl/core/hmp_pkg.sv =====
// shared types, constants and byte packing for the message padder
package hmp_pkg;

    localparam logic [7:0] PAD_MARKER = 8'h80;
    localparam logic [5:0] LEN_FIRST_POS = 6'd56;
    localparam logic [1:0] LAST_LANE = 2'd3;
    localparam logic [3:0] LAST_WORD_IN_BLOCK = 4'd15;

    // commands from the controller to the datapath
    typedef struct packed {
        logic       byte_en;
        logic       pad_en;
        logic [4:0] pad_word;
        logic       pad_len;
        logic       pad_last;
    } t_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic       slot_free;
        logic [5:0] block_pos;
    } t_status;

    // b0 is the first byte of the word in message order
    function automatic logic [31:0] pack_word(input logic big, input logic [7:0] b0,
                                              input logic [7:0] b1, input logic [7:0] b2,
                                              input logic [7:0] b3);
        logic [31:0] w;
        if (big) begin
            w = {b0, b1, b2, b3};
        end else begin
            w = {b3, b2, b1, b0};
        end
        return w;
    endfunction

endpackage

// ===== rtl/core/hmp_ctrl.sv =====
// padder controller: input acceptance and padding word sequencer
module hmp_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_req_type,
    output logic             o_in_stall,
    input  hmp_pkg::t_status i_status,
    output hmp_pkg::t_cmd    o_cmd
);
    import hmp_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_PAD  = 1'b1;
    localparam logic [4:0] END_ONE_BLOCK = 5'd15;
    localparam logic [4:0] END_TWO_BLOCK = 5'd31;

    logic       r_state, n_state;
    logic [4:0] r_word, n_word;
    logic [4:0] r_end, n_end;
    logic       accept;
    logic       pad_go;

    assign o_in_stall = (r_state == ST_PAD) || !i_status.slot_free;
    assign accept     = i_in_valid && !o_in_stall;
    assign pad_go     = (r_state == ST_PAD) && i_status.slot_free;

    always_comb begin
        n_state = r_state;
        n_word  = r_word;
        n_end   = r_end;
        case (r_state)
            ST_IDLE: begin
                if (accept && i_req_type) begin
                    n_state = ST_PAD;
                    n_word  = {1'b0, i_status.block_pos[5:2]};
                    // fewer than 8 free bytes after the marker: extra block
                    n_end   = (i_status.block_pos >= LEN_FIRST_POS) ? END_TWO_BLOCK
                                                                    : END_ONE_BLOCK;
                end
            end
            ST_PAD: begin
                if (pad_go) begin
                    n_word = r_word + 5'd1;
                    if (r_word == r_end) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_word  <= '0;
            r_end   <= '0;
        end else begin
            r_state <= n_state;
            r_word  <= n_word;
            r_end   <= n_end;
        end
    end

    always_comb begin
        o_cmd.byte_en  = accept && !i_req_type;
        o_cmd.pad_en   = pad_go;
        o_cmd.pad_word = r_word;
        o_cmd.pad_len  = (r_word == r_end) || (r_word == (r_end - 5'd1));
        o_cmd.pad_last = (r_word == r_end);
    end

endmodule

// ===== rtl/core/hmp_dp.sv =====
// padder datapath: message state, word assembly, padding bytes and output register
module hmp_dp (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_wdata,
    input  logic [7:0]       i_data_byte,
    input  hmp_pkg::t_cmd    i_cmd,
    output hmp_pkg::t_status o_status,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [31:0]      o_block_word,
    output logic [3:0]       o_word_index,
    output logic             o_block_end,
    output logic             o_message_end,
    output logic             o_run_last
);
    import hmp_pkg::*;

    logic        r_order;
    logic [5:0]  r_pos;
    logic [60:0] r_msg;
    logic [23:0] r_asm;

    logic        r_valid;
    logic [31:0] r_word;
    logic [3:0]  r_index;
    logic        r_bend;
    logic        r_mend;
    logic        r_last;

    logic        slot_free;
    logic        byte_word;
    logic        load;
    logic [63:0] bits;
    logic [7:0]  pb [4];
    logic        mark_word;
    logic [2:0]  li;
    logic [2:0]  sel;
    logic [31:0] n_word;
    logic [3:0]  n_index;
    logic        n_mend;
    logic        n_last;

    assign slot_free = !r_valid || !i_out_stall;
    assign byte_word = i_cmd.byte_en && (r_pos[1:0] == LAST_LANE);
    assign load      = byte_word || i_cmd.pad_en;
    assign bits      = {r_msg, 3'b000};
    assign mark_word = (i_cmd.pad_word == {1'b0, r_pos[5:2]});

    // padding bytes of the word under construction
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            li  = {i_cmd.pad_word[0], 2'(k)};
            sel = r_order ? (3'd7 - li) : li;
            pb[k] = 8'h00;
            if (i_cmd.pad_len) begin
                pb[k] = bits[{sel, 3'b000} +: 8];
            end else if (mark_word && (2'(k) == r_pos[1:0])) begin
                pb[k] = PAD_MARKER;
            end else if (mark_word && (2'(k) < r_pos[1:0])) begin
                pb[k] = (k < 3) ? r_asm[8*(k%3) +: 8] : 8'h00;
            end
        end
    end

    always_comb begin
        if (i_cmd.pad_en) begin
            n_word  = pack_word(r_order, pb[0], pb[1], pb[2], pb[3]);
            n_index = i_cmd.pad_word[3:0];
            n_mend  = i_cmd.pad_last;
            n_last  = i_cmd.pad_last;
        end else begin
            n_word  = pack_word(r_order, r_asm[7:0], r_asm[15:8], r_asm[23:16], i_data_byte);
            n_index = r_pos[5:2];
            n_mend  = 1'b0;
            n_last  = 1'b1;
        end
    end

    // message state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order <= 1'b0;
            r_pos   <= '0;
            r_msg   <= '0;
            r_asm   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_order <= i_cfg_wdata;
            end
            if (i_cmd.byte_en) begin
                r_pos <= r_pos + 6'd1;
                r_msg <= r_msg + 61'd1;
                case (r_pos[1:0])
                    2'd0:    r_asm[7:0]   <= i_data_byte;
                    2'd1:    r_asm[15:8]  <= i_data_byte;
                    2'd2:    r_asm[23:16] <= i_data_byte;
                    default: r_asm        <= '0;
                endcase
            end else if (i_cmd.pad_en && i_cmd.pad_last) begin
                r_pos <= '0;
                r_msg <= '0;
                r_asm <= '0;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= load || (r_valid && i_out_stall);
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_word  <= n_word;
            r_index <= n_index;
            r_bend  <= (n_index == LAST_WORD_IN_BLOCK);
            r_mend  <= n_mend;
            r_last  <= n_last;
        end
    end

    always_comb begin
        o_status.slot_free = slot_free;
        o_status.block_pos = r_pos;
    end

    assign o_out_valid   = r_valid;
    assign o_block_word  = r_word;
    assign o_word_index  = r_index;
    assign o_block_end   = r_bend;
    assign o_message_end = r_mend;
    assign o_run_last    = r_last;

endmodule

// ===== rtl/core/hash_message_padder.sv =====
// top level of the 512-bit block message padder
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+--------------------------------------
//  in      | input     | i_in_valid / o_in_stall  | i_req_type, i_data_byte
//  out     | output    | o_out_valid / i_out_stall| o_block_word, o_word_index, o_block_end,
//          |           |                          | o_message_end, o_run_last
//  cfg     | input     | i_cfg_we                 | i_cfg_wdata (byte order)
//
// message bytes stream back to back while the output register drains
// an end-of-message item is accepted, then the sequencer emits 3 to 18 padded words,
// one per cycle while the output register drains
// the input is stalled while padding words are generated and while the output register is held
// the output register is the single result slot, so a stall on out stalls in as well
// reset is synchronous and clears all message state and the byte order to little-endian
module hash_message_padder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_req_type,
    input  logic [7:0]  i_data_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_block_word,
    output logic [3:0]  o_word_index,
    output logic        o_block_end,
    output logic        o_message_end,
    output logic        o_run_last
);
    import hmp_pkg::*;

    t_cmd    cmd;
    t_status status;

    hmp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_req_type (i_req_type),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    hmp_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_data_byte   (i_data_byte),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_block_word  (o_block_word),
        .o_word_index  (o_word_index),
        .o_block_end   (o_block_end),
        .o_message_end (o_message_end),
        .o_run_last    (o_run_last)
    );

endmodule

// ===== rtl/core/hmp_checker.sv =====
// port-level assertions for the message padder and their bind
module hmp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        i_req_type,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [31:0] o_block_word,
    input logic [3:0]  o_word_index,
    input logic        o_block_end,
    input logic        o_message_end,
    input logic        o_run_last
);

    // held transaction keeps its word, index and run_last flag
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_block_word)
            && $stable(o_word_index) && $stable(o_run_last))
        else $error("stalled output transaction changed");

    a_block_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_block_end == (o_word_index == 4'd15)))
        else $error("block_end does not match word index");

    a_msg_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_message_end |-> o_run_last && o_block_end)
        else $error("message end not on last word of a block");

    // padding words follow one another without gaps
    a_pad_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_run_last |=>
            o_out_valid && (o_word_index == 4'($past(o_word_index) + 4'd1)))
        else $error("padding word sequence broken");

    a_end_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_req_type |=> o_in_stall)
        else $error("input taken during padding");

endmodule

bind hash_message_padder hmp_checker u_hmp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .i_req_type    (i_req_type),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_block_word  (o_block_word),
    .o_word_index  (o_word_index),
    .o_block_end   (o_block_end),
    .o_message_end (o_message_end),
    .o_run_last    (o_run_last)
);

// ===== verif/tb_hash_message_padder.sv =====
// self-checking testbench for the 512-bit block message padder
module tb_hash_message_padder;

    import hmp_pkg::PAD_MARKER;
    import hmp_pkg::LEN_FIRST_POS;
    import hmp_pkg::LAST_WORD_IN_BLOCK;

    typedef enum logic {REQ_BYTE = 1'b0, REQ_END = 1'b1} t_req_kind;
    typedef enum logic {ORDER_LITTLE = 1'b0, ORDER_BIG = 1'b1} t_byte_order;

    localparam int STALL_NONE     = 0;
    localparam int STALL_RANDOM   = 1;
    localparam int STALL_PERIODIC = 2;
    localparam int STALL_LONG     = 3;

    localparam int CYCLE_LIMIT = 300000;
    localparam int DRAIN_CYCLES = 30;
    localparam int RANDOM_ITEMS = 170;

    typedef struct packed {
        logic [31:0] word;
        logic [3:0]  index;
        logic        blk_end;
        logic        msg_end;
        logic        run_last;
    } t_padded_word;

    // one directed transaction; a typed word overrides the first expected word it causes
    typedef struct packed {
        logic        wr_order;
        t_byte_order order;
        t_req_kind   req;
        logic [7:0]  data;
        logic        has_word;
        logic [31:0] word;
    } t_dir_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_wdata;
    logic        i_in_valid;
    logic        o_in_stall;
    logic        i_req_type;
    logic [7:0]  i_data_byte;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [31:0] o_block_word;
    logic [3:0]  o_word_index;
    logic        o_block_end;
    logic        o_message_end;
    logic        o_run_last;

    hash_message_padder DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_req_type    (i_req_type),
        .i_data_byte   (i_data_byte),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_block_word  (o_block_word),
        .o_word_index  (o_word_index),
        .o_block_end   (o_block_end),
        .o_message_end (o_message_end),
        .o_run_last    (o_run_last)
    );

    // predictor state
    t_byte_order  pad_order;
    logic [5:0]   pad_pos;
    logic [60:0]  pad_len_bytes;
    logic [23:0]  pad_partial;
    t_padded_word pending_words[$];

    t_dir_row dir_rows[$];
    int       mismatches;
    int       words_checked;
    int       items_sent;
    int       messages_done;
    int       extra_blocks;
    int       big_messages;
    int       cycle_cnt;
    logic     rst_done;
    logic     idle_on;
    int       burst_left;
    int       stall_mode;
    int       stall_phase_left;
    int       stall_hold;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // words arrive in message order: bits 31:24 hold the first byte
    function automatic logic [31:0] order_word(logic [31:0] msg_word, t_byte_order order);
        if (order == ORDER_BIG) begin
            return msg_word;
        end
        return {msg_word[7:0], msg_word[15:8], msg_word[23:16], msg_word[31:24]};
    endfunction

    function automatic void push_word(logic [31:0] msg_word, logic [3:0] index,
                                      logic msg_end, logic run_last);
        t_padded_word w;
        w.word     = order_word(msg_word, pad_order);
        w.index    = index;
        w.blk_end  = (index == LAST_WORD_IN_BLOCK);
        w.msg_end  = msg_end;
        w.run_last = run_last;
        pending_words.push_back(w);
    endfunction

    function automatic void predict_padding(t_req_kind req, logic [7:0] data);
        logic [7:0]  tail[0:127];
        logic [63:0] bit_len;
        int unsigned pos;
        int unsigned offs;
        int unsigned start;
        int unsigned total;
        pos  = pad_pos;
        offs = pos % 4;
        if (req == REQ_BYTE) begin
            pad_len_bytes = pad_len_bytes + 61'd1;
            pad_pos       = pad_pos + 6'd1;
            if (offs < 3) begin
                pad_partial[8*offs +: 8] = data;
            end else begin
                push_word({pad_partial[7:0], pad_partial[15:8], pad_partial[23:16], data},
                          4'(pos / 4), 1'b0, 1'b1);
                pad_partial = '0;
            end
            return;
        end
        total = (pos < LEN_FIRST_POS) ? 64 : 128;
        start = pos - offs;
        if (total == 128) extra_blocks++;
        for (int i = 0; i < 128; i++) tail[i] = 8'h00;
        for (int i = 0; i < offs; i++) tail[start + i] = pad_partial[8*i +: 8];
        tail[pos] = PAD_MARKER;
        bit_len = {pad_len_bytes, 3'b000};
        for (int i = 0; i < 8; i++) begin
            tail[total - 8 + i] = (pad_order == ORDER_BIG) ? bit_len[8*(7-i) +: 8]
                                                            : bit_len[8*i +: 8];
        end
        for (int i = start; i < total; i += 4) begin
            push_word({tail[i], tail[i+1], tail[i+2], tail[i+3]}, 4'((i / 4) % 16),
                      (i + 4) == total, (i + 4) == total);
        end
        if (pad_order == ORDER_BIG) big_messages++;
        messages_done++;
        pad_pos       = '0;
        pad_len_bytes = '0;
        pad_partial   = '0;
    endfunction

    function automatic t_dir_row row(logic wr_order, t_byte_order order, t_req_kind req,
                                     logic [7:0] data, logic has_word, logic [31:0] word);
        t_dir_row r;
        r.wr_order = wr_order;
        r.order    = order;
        r.req      = req;
        r.data     = data;
        r.has_word = has_word;
        r.word     = word;
        return r;
    endfunction

    // called at a falling edge; returns at a falling edge with the block idle
    task automatic write_order(t_byte_order order);
        i_in_valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (20) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= order;
        @(negedge i_clk);
        i_cfg_we  <= 1'b0;
        pad_order = order;
        burst_left = 0;
    endtask

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_item(t_req_kind req, logic [7:0] data, logic has_word,
                             logic [31:0] word);
        int first;
        if (burst_left == 0) begin
            if (idle_on) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        i_in_valid  <= 1'b1;
        i_req_type  <= req;
        i_data_byte <= data;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        first = pending_words.size();
        predict_padding(req, data);
        if (has_word) pending_words[first].word = word;
        items_sent++;
        burst_left--;
        @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d words outstanding", $time, pending_words.size());
            $display("Mismatches found");
            $finish;
        end
    end

    // receiver stall pattern is picked anew at the start of each phase of random length
    always @(negedge i_clk) begin
        if (stall_phase_left == 0) begin
            stall_mode       = $urandom_range(STALL_NONE, STALL_LONG);
            stall_phase_left = $urandom_range(20, 80);
        end
        stall_phase_left--;
        case (stall_mode)
            STALL_NONE: begin
                i_out_stall <= 1'b0;
            end
            STALL_RANDOM: begin
                i_out_stall <= ($urandom_range(0, 3) == 0);
            end
            STALL_PERIODIC: begin
                i_out_stall <= (cycle_cnt % 5 < 2);
            end
            default: begin
                if (stall_hold > 0) begin
                    stall_hold--;
                    i_out_stall <= 1'b1;
                end else if ($urandom_range(0, 11) == 0) begin
                    stall_hold = $urandom_range(3, 20);
                    i_out_stall <= 1'b1;
                end else begin
                    i_out_stall <= 1'b0;
                end
            end
        endcase
    end

    always @(posedge i_clk) begin
        t_padded_word exp_w;
        if (rst_done && o_out_valid === 1'b1 && !i_out_stall) begin
            if (pending_words.size() == 0) begin
                $display("%0t: unexpected word, expected none, actual %h idx %0d",
                         $time, o_block_word, o_word_index);
                mismatches++;
            end else begin
                exp_w = pending_words.pop_front();
                words_checked++;
                if (o_block_word !== exp_w.word) begin
                    $display("%0t: block_word expected %h actual %h",
                             $time, exp_w.word, o_block_word);
                    mismatches++;
                end
                if (o_word_index !== exp_w.index) begin
                    $display("%0t: word_index expected %0d actual %0d",
                             $time, exp_w.index, o_word_index);
                    mismatches++;
                end
                if (o_block_end !== exp_w.blk_end) begin
                    $display("%0t: block_end expected %b actual %b",
                             $time, exp_w.blk_end, o_block_end);
                    mismatches++;
                end
                if (o_message_end !== exp_w.msg_end) begin
                    $display("%0t: message_end expected %b actual %b",
                             $time, exp_w.msg_end, o_message_end);
                    mismatches++;
                end
                if (o_run_last !== exp_w.run_last) begin
                    $display("%0t: run_last expected %b actual %b",
                             $time, exp_w.run_last, o_run_last);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        int msg_len;
        int pick;
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_wdata      = 1'b0;
        i_in_valid       = 1'b0;
        i_req_type       = REQ_BYTE;
        i_data_byte      = 8'h00;
        i_out_stall      = 1'b0;
        rst_done         = 1'b0;
        cycle_cnt        = 0;
        mismatches       = 0;
        words_checked    = 0;
        items_sent       = 0;
        messages_done    = 0;
        extra_blocks     = 0;
        big_messages     = 0;
        burst_left       = 0;
        idle_on          = 1'b1;
        stall_mode       = STALL_NONE;
        stall_phase_left = 0;
        stall_hold       = 0;
        pad_order        = ORDER_LITTLE;
        pad_pos          = '0;
        pad_len_bytes    = '0;
        pad_partial      = '0;

        // empty message with the data byte ignored, then byte extremes, then big endian
        dir_rows.push_back(row(1'b1, ORDER_LITTLE, REQ_END,  8'hFF, 1'b1, 32'h0000_0080));
        dir_rows.push_back(row(1'b0, ORDER_LITTLE, REQ_BYTE, 8'h00, 1'b0, 32'h0));
        dir_rows.push_back(row(1'b0, ORDER_LITTLE, REQ_BYTE, 8'hFF, 1'b0, 32'h0));
        dir_rows.push_back(row(1'b0, ORDER_LITTLE, REQ_BYTE, 8'h00, 1'b0, 32'h0));
        dir_rows.push_back(row(1'b0, ORDER_LITTLE, REQ_BYTE, 8'hFF, 1'b1, 32'hFF00_FF00));
        dir_rows.push_back(row(1'b0, ORDER_LITTLE, REQ_BYTE, 8'hFF, 1'b0, 32'h0));
        dir_rows.push_back(row(1'b0, ORDER_LITTLE, REQ_BYTE, 8'hFF, 1'b0, 32'h0));
        dir_rows.push_back(row(1'b0, ORDER_LITTLE, REQ_BYTE, 8'hFF, 1'b0, 32'h0));
        dir_rows.push_back(row(1'b0, ORDER_LITTLE, REQ_BYTE, 8'hFF, 1'b1, 32'hFFFF_FFFF));
        dir_rows.push_back(row(1'b0, ORDER_LITTLE, REQ_BYTE, 8'h01, 1'b0, 32'h0));
        dir_rows.push_back(row(1'b0, ORDER_LITTLE, REQ_BYTE, 8'h02, 1'b0, 32'h0));
        dir_rows.push_back(row(1'b0, ORDER_LITTLE, REQ_BYTE, 8'h03, 1'b0, 32'h0));
        dir_rows.push_back(row(1'b0, ORDER_LITTLE, REQ_END,  8'h00, 1'b1, 32'h8003_0201));
        dir_rows.push_back(row(1'b1, ORDER_BIG,    REQ_BYTE, 8'h01, 1'b0, 32'h0));
        dir_rows.push_back(row(1'b0, ORDER_BIG,    REQ_BYTE, 8'h02, 1'b0, 32'h0));
        dir_rows.push_back(row(1'b0, ORDER_BIG,    REQ_BYTE, 8'h03, 1'b0, 32'h0));
        dir_rows.push_back(row(1'b0, ORDER_BIG,    REQ_BYTE, 8'h04, 1'b1, 32'h0102_0304));
        dir_rows.push_back(row(1'b0, ORDER_BIG,    REQ_BYTE, 8'hAA, 1'b0, 32'h0));
        dir_rows.push_back(row(1'b0, ORDER_BIG,    REQ_END,  8'h00, 1'b1, 32'hAA80_0000));
        dir_rows.push_back(row(1'b0, ORDER_BIG,    REQ_END,  8'h5A, 1'b1, 32'h8000_0000));

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n  <= 1'b1;
        rst_done <= 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[n]) begin
            if (dir_rows[n].wr_order) write_order(dir_rows[n].order);
            send_item(dir_rows[n].req, dir_rows[n].data, dir_rows[n].has_word,
                      dir_rows[n].word);
        end

        // random messages, many of them ending near the length field, where an extra block may be needed
        while (items_sent < dir_rows.size() + RANDOM_ITEMS) begin
            if ($urandom_range(0, 2) == 0) begin
                write_order($urandom_range(0, 1) ? ORDER_BIG : ORDER_LITTLE);
            end
            idle_on = ($urandom_range(0, 3) != 0);
            pick = $urandom_range(0, 9);
            if (pick < 4) begin
                msg_len = $urandom_range(0, 8);
            end else if (pick < 7) begin
                msg_len = $urandom_range(52, 64);
            end else begin
                msg_len = $urandom_range(0, 70);
            end
            for (int k = 0; k < msg_len; k++) begin
                send_item(REQ_BYTE, 8'($urandom_range(0, 255)), 1'b0, 32'h0);
            end
            send_item(REQ_END, 8'($urandom_range(0, 255)), 1'b0, 32'h0);
        end
        i_in_valid <= 1'b0;

        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("sent %0d transactions in %0d messages (%0d big endian, %0d with an extra block)",
                 items_sent, messages_done, big_messages, extra_blocks);
        $display("checked %0d padded words under mixed input gaps and output stalls",
                 words_checked);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
